### sv/vt4_pkg.sv
`default_nettype none
package vt4_pkg;

  localparam int WORD_W      = 32;
  localparam int IDX_W       = 4;
  localparam int MAT_N       = 4;
  localparam int MAT_ENTRIES = MAT_N * MAT_N;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int PAIR_W      = PROD_W + 1;
  localparam int SUM_W       = PROD_W + 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Queue entry: a load carries its value in vec[0]
  typedef struct packed {
    logic                          is_load;
    logic [IDX_W-1:0]              idx;
    logic [MAT_N-1:0][WORD_W-1:0]  vec;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage
`default_nettype wire

### sv/vt4_in_if.sv
`default_nettype none
interface vt4_in_if;
  import vt4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IDX_W-1:0]         elem_index;
  logic signed [WORD_W-1:0] elem_value;
  logic signed [WORD_W-1:0] in_x;
  logic signed [WORD_W-1:0] in_y;
  logic signed [WORD_W-1:0] in_z;
  logic signed [WORD_W-1:0] in_w;

  modport source (
    output valid, op, elem_index, elem_value, in_x, in_y, in_z, in_w,
    input  ready
  );

  modport sink (
    input  valid, op, elem_index, elem_value, in_x, in_y, in_z, in_w,
    output ready
  );

endinterface
`default_nettype wire

### sv/vt4_out_if.sv
`default_nettype none
interface vt4_out_if;
  import vt4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] out_x;
  logic signed [WORD_W-1:0] out_y;
  logic signed [WORD_W-1:0] out_z;
  logic signed [WORD_W-1:0] out_w;
  logic                     overflow;

  modport source (
    output valid, out_x, out_y, out_z, out_w, overflow,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w, overflow,
    output ready
  );

endinterface
`default_nettype wire

### sv/vertex_transform_4x4_top.sv
`default_nettype none
// A transform beat passes the queue write, the multiply stage, the pair-sum stage, and the final
//   sum and saturate into the output reg before it shows on result_out.
// Throughput: one beat per cycle, loads and transforms alike, unless result_out stalls; set by
//   the 16 parallel multipliers. Loads give no result and update the matrix at the queue head.
// Reset: synchronous, active high; clears queue pointers and stage valids, matrix is not cleared.
module vertex_transform_4x4_top #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  vt4_in_if.sink     item_in,
  vt4_out_if.source  result_out
);
  import vt4_pkg::*;

  head_t head;
  logic  pop;

  vt4_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .item_in (item_in),
    .head    (head),
    .pop     (pop)
  );

  vt4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .result_out (result_out)
  );

  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_stall_holds_xform: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && !result_out.ready) |-> !(pop && !head.cmd.is_load))
    else $error("transform issued into stalled pipeline");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(rst) |-> !result_out.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

### sv/vt4_front.sv
`default_nettype none
module vt4_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  vt4_in_if.sink          item_in,
  output vt4_pkg::head_t  head,
  input  logic            pop
);
  import vt4_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t               queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  cmd_t               cmd;
  logic               push;
  logic               do_pop;

  always_comb begin
    cmd.is_load = (item_in.op == OP_LOAD);
    cmd.idx     = item_in.elem_index;
    if (item_in.op == OP_LOAD) begin
      cmd.vec = {{(MAT_N-1)*WORD_W{1'b0}}, item_in.elem_value};
    end else begin
      cmd.vec = {item_in.in_w, item_in.in_z, item_in.in_y, item_in.in_x};
    end
  end

  assign item_in.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push          = item_in.valid && item_in.ready;
  assign head.valid    = (count != '0);
  assign head.cmd      = queue[rd_ptr];
  assign do_pop        = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### sv/vt4_back.sv
`default_nettype none
module vt4_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  vt4_pkg::head_t  head,
  output logic            pop,
  vt4_out_if.source       result_out
);
  import vt4_pkg::*;

  logic [MAT_ENTRIES-1:0][WORD_W-1:0] mat;
  logic signed [PROD_W-1:0]           prod [MAT_N][MAT_N];
  logic signed [PAIR_W-1:0]           pair [MAT_N][2];
  logic signed [SUM_W-1:0]            sum  [MAT_N];
  logic signed [SUM_W-1:0]            shifted [MAT_N];
  logic [MAT_N-1:0]                   sat;
  logic [MAT_N-1:0][WORD_W-1:0]       res;
  logic                               en;
  logic                               take_xform;
  logic                               s1_valid;
  logic                               s2_valid;

  assign en         = !result_out.valid || result_out.ready;
  assign take_xform = head.valid && !head.cmd.is_load && en;
  assign pop        = head.valid && (head.cmd.is_load || en);

  // loads retire straight from the queue head
  always_ff @(posedge clk) begin
    if (head.valid && head.cmd.is_load) begin
      mat[head.cmd.idx] <= head.cmd.vec[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < MAT_N; r++) begin
        for (int c = 0; c < MAT_N; c++) begin
          prod[r][c] <= $signed(mat[r*MAT_N + c]) * $signed(head.cmd.vec[c]);
        end
      end
      for (int r = 0; r < MAT_N; r++) begin
        pair[r][0] <= PAIR_W'(prod[r][0]) + PAIR_W'(prod[r][1]);
        pair[r][1] <= PAIR_W'(prod[r][2]) + PAIR_W'(prod[r][3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAT_N; r++) begin
      sum[r]     = SUM_W'(pair[r][0]) + SUM_W'(pair[r][1]);
      shifted[r] = sum[r] >>> FRAC_BITS;
      sat[r]     = !((&shifted[r][SUM_W-1:WORD_W-1]) || !(|shifted[r][SUM_W-1:WORD_W-1]));
      if (sat[r]) begin
        res[r] = shifted[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        res[r] = shifted[r][WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_out.out_x    <= res[0];
      result_out.out_y    <= res[1];
      result_out.out_z    <= res[2];
      result_out.out_w    <= res[3];
      result_out.overflow <= |sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      s2_valid         <= 1'b0;
      result_out.valid <= 1'b0;
    end else if (en) begin
      s1_valid         <= take_xform;
      s2_valid         <= s1_valid;
      result_out.valid <= s2_valid;
    end
  end

endmodule
`default_nettype wire

### test/vt4_result_checker.sv
module vt4_result_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       in_op,
  input  logic [vt4_pkg::IDX_W-1:0]  in_idx,
  input  logic [vt4_pkg::WORD_W-1:0] in_value,
  input  logic [vt4_pkg::WORD_W-1:0] in_x,
  input  logic [vt4_pkg::WORD_W-1:0] in_y,
  input  logic [vt4_pkg::WORD_W-1:0] in_z,
  input  logic [vt4_pkg::WORD_W-1:0] in_w,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [vt4_pkg::WORD_W-1:0] out_x,
  input  logic [vt4_pkg::WORD_W-1:0] out_y,
  input  logic [vt4_pkg::WORD_W-1:0] out_z,
  input  logic [vt4_pkg::WORD_W-1:0] out_w,
  input  logic                       out_ovf,
  output int                         fail_count,
  output int                         pending,
  output int                         results_seen,
  output int                         saturated_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import vt4_pkg::*;

  typedef struct packed {
    logic [MAT_N-1:0][WORD_W-1:0] row_dot;
    logic                         ovf;
  } xform_res_t;

  logic [WORD_W-1:0] shadow_mat [MAT_ENTRIES];
  xform_res_t        expected_xforms [$];

  // exact 66-bit row sums, floor shift, saturate to 32 bits
  function automatic xform_res_t predict_xform(input logic [MAT_N-1:0][WORD_W-1:0] vec);
    xform_res_t               res;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc;
    res.ovf = 1'b0;
    for (int r = 0; r < MAT_N; r++) begin
      acc = '0;
      for (int c = 0; c < MAT_N; c++) begin
        prod = $signed(shadow_mat[r*MAT_N + c]) * $signed(vec[c]);
        acc  = acc + prod;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > $signed(SAT_MAX)) begin
        res.row_dot[r] = SAT_MAX;
        res.ovf        = 1'b1;
      end else if (acc < $signed(SAT_MIN)) begin
        res.row_dot[r] = SAT_MIN;
        res.ovf        = 1'b1;
      end else begin
        res.row_dot[r] = acc[WORD_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch_beats
    xform_res_t got;
    xform_res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.row_dot = {out_w, out_z, out_y, out_x};
        got.ovf     = out_ovf;
        results_seen++;
        if (got.ovf) saturated_seen++;
        if (expected_xforms.size() == 0) begin
          $display("%0t: result beat with nothing expected: x=%h y=%h z=%h w=%h ovf=%b",
                   $time, out_x, out_y, out_z, out_w, out_ovf);
          fail_count++;
        end else begin
          want = expected_xforms.pop_front();
          for (int r = 0; r < MAT_N; r++) begin
            if (got.row_dot[r] !== want.row_dot[r]) begin
              $display("%0t: row %0d dot mismatch: expected %h actual %h",
                       $time, r, want.row_dot[r], got.row_dot[r]);
              fail_count++;
            end
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflow mismatch: expected %b actual %b",
                     $time, want.ovf, got.ovf);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_op == OP_LOAD) shadow_mat[in_idx] = in_value;
        else expected_xforms.push_back(predict_xform({in_w, in_z, in_y, in_x}));
      end
      pending = expected_xforms.size();
    end
  end

endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vt4_pkg::*;

  localparam int                FRAC_BITS    = 16;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam int                RANDOM_ITEMS = 1625;
  localparam logic [WORD_W-1:0] Q_ONE        = 32'h0001_0000;

  logic clk;
  logic rst;
  int   cycle_count = 0;
  int   n_loads     = 0;
  int   n_xforms    = 0;
  bit   src_calm    = 1'b0;
  bit   sink_calm   = 1'b0;

  int fail_count;
  int pending;
  int results_seen;
  int saturated_seen;

  vt4_in_if  item_ch ();
  vt4_out_if res_ch ();

  vertex_transform_4x4_top #(
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .item_in   (item_ch),
    .result_out(res_ch)
  );

  vt4_result_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (item_ch.valid),
    .in_ready      (item_ch.ready),
    .in_op         (item_ch.op),
    .in_idx        (item_ch.elem_index),
    .in_value      (item_ch.elem_value),
    .in_x          (item_ch.in_x),
    .in_y          (item_ch.in_y),
    .in_z          (item_ch.in_z),
    .in_w          (item_ch.in_w),
    .out_valid     (res_ch.valid),
    .out_ready     (res_ch.ready),
    .out_x         (res_ch.out_x),
    .out_y         (res_ch.out_y),
    .out_z         (res_ch.out_z),
    .out_w         (res_ch.out_w),
    .out_ovf       (res_ch.overflow),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .saturated_seen(saturated_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("vertex_transform_4x4_top verification failed");
      $finish;
    end
  end

  // small Q16.16 values most often, some extremes and full-range words
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 11))
      0:       v = SAT_MAX;
      1:       v = SAT_MIN;
      2:       v = '0;
      3:       v = Q_ONE;
      4, 5, 6: v = $urandom;
      default: begin
        v = $urandom_range(0, 32'h7_FFFF);
        v = v - 32'h4_0000;
      end
    endcase
    return v;
  endfunction

  task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] val, input logic [WORD_W-1:0] x,
                           input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] z,
                           input logic [WORD_W-1:0] w);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= op;
    item_ch.elem_index <= idx;
    item_ch.elem_value <= val;
    item_ch.in_x       <= x;
    item_ch.in_y       <= y;
    item_ch.in_z       <= z;
    item_ch.in_w       <= w;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if (op == OP_LOAD) n_loads++;
    else n_xforms++;
  endtask

  task automatic send_load(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    send_beat(OP_LOAD, idx, val, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_xform(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                            input logic [WORD_W-1:0] z, input logic [WORD_W-1:0] w);
    send_beat(OP_XFORM, IDX_W'($urandom_range(0, MAT_ENTRIES-1)), $urandom, x, y, z, w);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] v;
    item_ch.valid      <= 1'b0;
    item_ch.op         <= OP_LOAD;
    item_ch.elem_index <= '0;
    item_ch.elem_value <= '0;
    item_ch.in_x       <= '0;
    item_ch.in_y       <= '0;
    item_ch.in_z       <= '0;
    item_ch.in_w       <= '0;
    rst                <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // rows 0/1 at the extremes, rows 2/3 from the identity
    for (int i = 0; i < MAT_ENTRIES; i++) begin
      if (i < MAT_N) v = SAT_MAX;
      else if (i < 2*MAT_N) v = SAT_MIN;
      else v = (i % (MAT_N+1) == 0) ? Q_ONE : '0;
      send_load(IDX_W'(i), v);
    end
    send_xform(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    send_xform(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    send_xform('0, '0, '0, '0);
    send_xform(Q_ONE, -Q_ONE, 32'd1, -32'sd1);
    send_xform(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN);
    send_load(4'd15, -Q_ONE);
    send_load(4'd0, 32'd1);
    send_xform(Q_ONE, Q_ONE, Q_ONE, -32'sd3);
    send_xform($urandom, $urandom, $urandom, $urandom);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 125 == 0) begin
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 9) < 3)
        send_load(IDX_W'($urandom_range(0, MAT_ENTRIES-1)), rand_word());
      else send_xform(rand_word(), rand_word(), rand_word(), rand_word());
    end
    drain_results();

    $display("Sent %0d matrix loads and %0d vector transforms; checked %0d results,",
             n_loads, n_xforms, results_seen);
    $display("%0d of them saturated, with random gaps and stalls on both channels.",
             saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("vertex_transform_4x4_top verification clean");
    end else begin
      $display("vertex_transform_4x4_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/vt4_pkg.sv
sv/vt4_in_if.sv
sv/vt4_out_if.sv
sv/vt4_front.sv
sv/vt4_back.sv
sv/vertex_transform_4x4_top.sv
test/vt4_result_checker.sv
test/tb.sv
